// ----- rtl/ekrl_pkg.sv -----
// ----------------------------------------------------------------------------
// ekrl_pkg
// Shared types and constants of the multi-kind event ring log.
// ----------------------------------------------------------------------------
package ekrl_pkg;

    localparam int NUM_KINDS    = 6;
    localparam int MAX_SLOTS    = 256;
    localparam int NUM_CAP_REGS = 6;

    localparam int KIND_W      = 3;
    localparam int CNT_W       = 8;
    localparam int CAP_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int KIDX_W      = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int STORE_DEPTH = NUM_KINDS * MAX_SLOTS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int YEAR_W      = 6;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int HOUR_W      = 5;
    localparam int MINUTE_W    = 6;
    localparam int YEAR_FULL_W = 12;

    // Largest usable capacity: limited by the slot store and by the count width.
    localparam int CAP_LIMIT = (MAX_SLOTS > 255) ? 255 : MAX_SLOTS;

    localparam logic [YEAR_FULL_W-1:0] YEAR_BASE = 12'd2000;

    typedef logic [CAP_W-1:0] t_cap_array [NUM_CAP_REGS];
    localparam t_cap_array CAP_RESET = '{8'd200, 8'd200, 8'd100, 8'd100, 8'd50, 8'd50};

    typedef enum logic {
        REQ_LOG  = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    // Packed in the order year, month, day, hour, minute (year in the top bits).
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_stamp;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] newest;
    } t_ptr_entry;

    typedef struct packed {
        logic              rd_en;
        logic [KIDX_W-1:0] rd_idx;
        logic              wr_en;
        logic [KIDX_W-1:0] wr_idx;
        t_ptr_entry        wr_data;
    } t_ptr_req;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [STORE_AW-1:0] addr;
        t_stamp              wr_data;
    } t_store_req;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] a;
        logic [CAP_W-1:0] b;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [CAP_W-1:0] rem;
    } t_mod_rsp;

    typedef struct packed {
        logic                   found;
        logic [CNT_W-1:0]       order_number;
        logic [YEAR_FULL_W-1:0] year_full;
        logic [MONTH_W-1:0]     month_out;
        logic [DAY_W-1:0]       day_out;
        logic [HOUR_W-1:0]      hour_out;
        logic [MINUTE_W-1:0]    minute_out;
        logic [CNT_W-1:0]       stored_count;
    } t_result;

endpackage

// ----- rtl/ekrl_stream_if.sv -----
// ----------------------------------------------------------------------------
// ekrl_in_if / ekrl_out_if
// Valid/ready channels carrying request beats and result beats.
// ----------------------------------------------------------------------------
interface ekrl_in_if;
    import ekrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [KIND_W-1:0]   kind;
    logic [CNT_W-1:0]    entry_number;
    logic [YEAR_W-1:0]   year_in;
    logic [MONTH_W-1:0]  month_in;
    logic [DAY_W-1:0]    day_in;
    logic [HOUR_W-1:0]   hour_in;
    logic [MINUTE_W-1:0] minute_in;

    modport source (
        output valid, req_type, kind, entry_number,
        output year_in, month_in, day_in, hour_in, minute_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, kind, entry_number,
        input  year_in, month_in, day_in, hour_in, minute_in,
        output ready
    );
endinterface

interface ekrl_out_if;
    import ekrl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [CNT_W-1:0]       order_number;
    logic [YEAR_FULL_W-1:0] year_full;
    logic [MONTH_W-1:0]     month_out;
    logic [DAY_W-1:0]       day_out;
    logic [HOUR_W-1:0]      hour_out;
    logic [MINUTE_W-1:0]    minute_out;
    logic [CNT_W-1:0]       stored_count;

    modport source (
        output valid, found, order_number, year_full,
        output month_out, day_out, hour_out, minute_out, stored_count,
        input  ready
    );
    modport sink (
        input  valid, found, order_number, year_full,
        input  month_out, day_out, hour_out, minute_out, stored_count,
        output ready
    );
endinterface

// ----- rtl/multi_kind_event_ring_log.sv -----
// ----------------------------------------------------------------------------
// multi_kind_event_ring_log
// Six circular logs of timestamped events with per-kind capacities.
// ----------------------------------------------------------------------------
// A request beat on i_in either logs a timestamp into the next slot of one
// kind (req_type 0) or reads back entry number n of a kind, 1 being the
// oldest (req_type 1). Each request gives exactly one result beat on o_out.
// Capacities are set through the write port (i_cfg_we, i_cfg_idx,
// i_cfg_data); the user must write them only while no request is in
// flight, as the block itself does not enforce this. One request is
// worked on at a time; i_in.ready is high when the controller is free.
// A log request goes through the pointer read, calculation and done
// states, a read through pointer read, address calculation, store read
// and done, and a request with a bad kind goes straight to done. A read
// whose newest slot is at or beyond a lowered capacity passes through the
// remainder unit; the pointer memory and entry store reads are registered.
// The result sits in an output register; the next request is accepted while
// it waits, and only the hand-over of a further result stalls on o_out.ready.
// Reset empties all logs and restores the default capacities; the entry
// store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_kind_event_ring_log (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ekrl_in_if.sink                             i_in,
    ekrl_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [ekrl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ekrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ekrl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PTR,
        S_CALC,
        S_MOD,
        S_RD,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [CAP_W-1:0]    r_cap [NUM_CAP_REGS];
    t_req                r_req;
    logic [KIDX_W-1:0]   r_kidx;
    logic [CNT_W-1:0]    r_n;
    t_stamp              r_stamp;
    logic [CAP_W-1:0]    r_cap_eff;
    logic [CNT_W-1:0]    r_held;
    logic [CNT_W-1:0]    r_nm;
    t_result             r_res;
    t_result             r_out;
    logic                r_out_valid;

    t_ptr_req            ptr_req;
    t_ptr_entry          ptr_rd;
    t_store_req          st_req;
    t_stamp              st_rd;
    t_mod_req            mod_req;
    t_mod_rsp            mod_rsp;

    logic                in_acc;
    logic                kind_ok;
    logic [KIND_W-1:0]   kind_m1;
    logic [CAP_W-1:0]    cap_sel;
    logic [CAP_W-1:0]    cap_eff;
    logic [STORE_AW-1:0] base;
    logic [CNT_W:0]      nx_slot;
    logic [CNT_W-1:0]    slot_log;
    logic [CNT_W-1:0]    new_count;
    logic [CNT_W-1:0]    back;
    logic [CNT_W:0]      rd_sum;
    logic [CNT_W:0]      rd_wrap;
    logic [CNT_W-1:0]    slot_rd;
    logic                n_bad;
    logic                is_read;
    logic                need_mod;
    logic                load_out;

    ekrl_ptr_table u_ptr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ptr_req),
        .o_rd_data (ptr_rd)
    );

    ekrl_store u_store (
        .i_clk     (i_clk),
        .i_req     (st_req),
        .o_rd_data (st_rd)
    );

    ekrl_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        kind_ok = (i_in.kind != '0) && (int'(i_in.kind) <= NUM_KINDS);
        kind_m1 = i_in.kind - KIND_W'(1);
        cap_sel = r_cap[KIDX_W'(kind_m1)];
        if (cap_sel == '0) begin
            cap_eff = CAP_W'(1);
        end else if (int'(cap_sel) > CAP_LIMIT) begin
            cap_eff = CAP_W'(CAP_LIMIT);
        end else begin
            cap_eff = cap_sel;
        end

        base = STORE_AW'(r_kidx) * STORE_AW'(MAX_SLOTS);

        // Log: next slot wraps at the capacity; an empty log starts at slot zero.
        nx_slot  = {1'b0, r_nm} + (CNT_W+1)'(1);
        slot_log = ((r_held == '0) || (nx_slot >= {1'b0, r_cap_eff})) ? '0 :
                   nx_slot[CNT_W-1:0];
        new_count = (r_held < r_cap_eff) ? r_held + CNT_W'(1) : r_cap_eff;

        // Read: step back (held - n) slots from the newest, modulo the capacity.
        // Both the newest slot and the step are below the capacity here.
        back    = r_held - r_n;
        rd_sum  = {1'b0, r_nm} + {1'b0, r_cap_eff} - {1'b0, back};
        rd_wrap = rd_sum - {1'b0, r_cap_eff};
        slot_rd = (rd_sum >= {1'b0, r_cap_eff}) ? rd_wrap[CNT_W-1:0] : rd_sum[CNT_W-1:0];

        is_read  = (r_req == REQ_READ);
        n_bad    = (r_n == '0) || (r_n > r_held);
        need_mod = r_nm >= r_cap_eff;

        ptr_req         = '0;
        ptr_req.rd_en   = in_acc && kind_ok;
        ptr_req.rd_idx  = KIDX_W'(kind_m1);
        ptr_req.wr_idx  = r_kidx;
        ptr_req.wr_data = '{count: new_count, newest: slot_log};

        st_req         = '0;
        st_req.wr_data = r_stamp;
        st_req.addr    = base + STORE_AW'(is_read ? slot_rd : slot_log);

        mod_req   = '{start: 1'b0, a: r_nm, b: r_cap_eff};

        if (r_state == S_CALC) begin
            if (!is_read) begin
                ptr_req.wr_en = 1'b1;
                st_req.wr_en  = 1'b1;
            end else if (!n_bad) begin
                if (need_mod) begin
                    mod_req.start = 1'b1;
                end else begin
                    st_req.rd_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            if (i_cfg_we && (int'(i_cfg_idx) < NUM_CAP_REGS)) begin
                r_cap[i_cfg_idx] <= i_cfg_data;
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req     <= t_req'(i_in.req_type);
                        r_kidx    <= KIDX_W'(kind_m1);
                        r_n       <= i_in.entry_number;
                        r_stamp   <= '{year: i_in.year_in, month: i_in.month_in,
                                       day: i_in.day_in, hour: i_in.hour_in,
                                       minute: i_in.minute_in};
                        r_cap_eff <= cap_eff;
                        if (kind_ok) begin
                            r_state <= S_PTR;
                        end else begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PTR: begin
                    r_held  <= (ptr_rd.count > r_cap_eff) ? r_cap_eff : ptr_rd.count;
                    r_nm    <= ptr_rd.newest;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (!is_read) begin
                        r_res <= '{found: 1'b1, order_number: CNT_W'(1),
                                   year_full: YEAR_BASE + YEAR_FULL_W'(r_stamp.year),
                                   month_out: r_stamp.month, day_out: r_stamp.day,
                                   hour_out: r_stamp.hour, minute_out: r_stamp.minute,
                                   stored_count: new_count};
                        r_state <= S_DONE;
                    end else if (n_bad) begin
                        r_res   <= '{found: 1'b0, order_number: '0, year_full: '0,
                                     month_out: '0, day_out: '0, hour_out: '0,
                                     minute_out: '0, stored_count: r_held};
                        r_state <= S_DONE;
                    end else if (need_mod) begin
                        r_state <= S_MOD;
                    end else begin
                        r_res   <= '{found: 1'b1, order_number: back + CNT_W'(1),
                                     year_full: '0, month_out: '0, day_out: '0,
                                     hour_out: '0, minute_out: '0,
                                     stored_count: r_held};
                        r_state <= S_RD;
                    end
                end
                S_MOD: begin
                    if (mod_rsp.done) begin
                        r_nm    <= mod_rsp.rem;
                        r_state <= S_CALC;
                    end
                end
                S_RD: begin
                    r_res   <= '{found: r_res.found, order_number: r_res.order_number,
                                 year_full: YEAR_BASE + YEAR_FULL_W'(st_rd.year),
                                 month_out: st_rd.month, day_out: st_rd.day,
                                 hour_out: st_rd.hour, minute_out: st_rd.minute,
                                 stored_count: r_res.stored_count};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out.found;
    assign o_out.order_number = r_out.order_number;
    assign o_out.year_full    = r_out.year_full;
    assign o_out.month_out    = r_out.month_out;
    assign o_out.day_out      = r_out.day_out;
    assign o_out.hour_out     = r_out.hour_out;
    assign o_out.minute_out   = r_out.minute_out;
    assign o_out.stored_count = r_out.stored_count;

    // A request in flight keeps the input closed until its result is loaded into the output register.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input accepted while a request is in flight");

    // A pointer update never leaves a log empty or above its capacity.
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ptr_req.wr_en |-> (ptr_req.wr_data.count != '0) &&
                          (ptr_req.wr_data.count <= r_cap_eff) &&
                          (ptr_req.wr_data.newest < r_cap_eff))
        else $error("pointer update out of range");

    // Store reads stay inside the slots of the current capacity.
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_req.rd_en |-> (slot_rd < r_cap_eff) && !st_req.wr_en)
        else $error("store read outside capacity");

    // The remainder unit hands back a slot below the capacity.
    a_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_rsp.done |-> (mod_rsp.rem < r_cap_eff) && (r_state == S_MOD))
        else $error("remainder not below capacity");

    // A hit carries an order number between one and the held count.
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_res.found |-> (r_res.order_number != '0) &&
                                    (r_res.order_number <= r_res.stored_count))
        else $error("order number out of range");

endmodule

// ----- rtl/ekrl_ptr_table.sv -----
// ----------------------------------------------------------------------------
// ekrl_ptr_table
// Per-kind count and newest-slot memory, registered read.
// Entries never written since reset read as zero through their valid bits.
// ----------------------------------------------------------------------------
module ekrl_ptr_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ekrl_pkg::t_ptr_req    i_req,
    output ekrl_pkg::t_ptr_entry  o_rd_data
);
    import ekrl_pkg::*;

    t_ptr_entry            r_mem [NUM_KINDS];
    logic [NUM_KINDS-1:0]  r_vld;
    t_ptr_entry            r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- rtl/ekrl_store.sv -----
// ----------------------------------------------------------------------------
// ekrl_store
// Entry store for all kinds, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ekrl_store (
    input  logic                  i_clk,
    input  ekrl_pkg::t_store_req  i_req,
    output ekrl_pkg::t_stamp      o_rd_data
);
    import ekrl_pkg::*;

    t_stamp r_mem [STORE_DEPTH];
    t_stamp r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/ekrl_mod.sv -----
// ----------------------------------------------------------------------------
// ekrl_mod
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ekrl_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ekrl_pkg::t_mod_req  i_req,
    output ekrl_pkg::t_mod_rsp  o_rsp
);
    import ekrl_pkg::*;

    localparam int STEP_W = (CNT_W > 1) ? $clog2(CNT_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_a;
    logic [CAP_W-1:0]  r_b;
    logic [CAP_W-1:0]  r_rem;

    logic [CAP_W:0]    n_shift;
    logic [CAP_W:0]    n_diff;
    logic              n_ge;

    always_comb begin
        n_shift = {r_rem, r_a[CNT_W-1]};
        n_ge    = n_shift >= {1'b0, r_b};
        n_diff  = n_shift - {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(CNT_W - 1);
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_rem  <= '0;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so it fits CAP_W bits.
                r_rem <= n_ge ? n_diff[CAP_W-1:0] : n_shift[CAP_W-1:0];
                r_a   <= {r_a[CNT_W-2:0], 1'b0};
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- tb/multi_kind_event_ring_log_tb.sv -----
// ----------------------------------------------------------------------------
// multi_kind_event_ring_log_tb
// Self-checking testbench for the multi-kind event ring log.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first. Some rows carry a typed-in
// expectation and the rest are checked by the predictor. Random phases follow,
// each under its own set of capacities, written while the block is idle.
// Request beats go out in bursts with random gaps, and result beats are taken
// under a changing stall pattern. Every result beat is compared field by field
// with the oldest expectation.
// ----------------------------------------------------------------------------
module multi_kind_event_ring_log_tb;
    import ekrl_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RUN_LIMIT       = 4_000_000;

    typedef logic [CAP_W-1:0] t_capset [NUM_CAP_REGS];

    typedef struct packed {
        t_req              op;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  entry_no;
        t_stamp            stamp;
    } t_request;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_result  want;
    } t_dir_row;

    localparam int DIR_ROWS_N = 20;

    // Rows with typed = 1 carry an expectation that follows from reset state.
    localparam t_dir_row DIR_ROWS [DIR_ROWS_N] = '{
        '{'{REQ_READ, 3'd1, 8'd1, '0}, 1'b1, '0},
        '{'{REQ_LOG, 3'd0, 8'd0, '{6'd63, 4'd15, 5'd31, 5'd31, 6'd63}}, 1'b1, '0},
        '{'{REQ_READ, 3'd7, 8'd1, '0}, 1'b1, '0},
        '{'{REQ_LOG, 3'd1, 8'd255, '{6'd63, 4'd15, 5'd31, 5'd31, 6'd63}}, 1'b1,
          '{1'b1, 8'd1, 12'd2063, 4'd15, 5'd31, 5'd31, 6'd63, 8'd1}},
        '{'{REQ_LOG, 3'd1, 8'd0, '0}, 1'b1,
          '{1'b1, 8'd1, 12'd2000, 4'd0, 5'd0, 5'd0, 6'd0, 8'd2}},
        '{'{REQ_READ, 3'd1, 8'd1, '0}, 1'b1,
          '{1'b1, 8'd2, 12'd2063, 4'd15, 5'd31, 5'd31, 6'd63, 8'd2}},
        '{'{REQ_READ, 3'd1, 8'd2, '0}, 1'b1,
          '{1'b1, 8'd1, 12'd2000, 4'd0, 5'd0, 5'd0, 6'd0, 8'd2}},
        '{'{REQ_READ, 3'd1, 8'd0, '0}, 1'b1,
          '{1'b0, 8'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 8'd2}},
        '{'{REQ_READ, 3'd1, 8'd3, '0}, 1'b1,
          '{1'b0, 8'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 8'd2}},
        '{'{REQ_READ, 3'd1, 8'd255, '0}, 1'b1,
          '{1'b0, 8'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 8'd2}},
        '{'{REQ_LOG, 3'd6, 8'd0, '{6'd5, 4'd12, 5'd1, 5'd23, 6'd59}}, 1'b1,
          '{1'b1, 8'd1, 12'd2005, 4'd12, 5'd1, 5'd23, 6'd59, 8'd1}},
        '{'{REQ_LOG, 3'd2, 8'h5a, '{6'd21, 4'd6, 5'd15, 5'd8, 6'd30}}, 1'b0, '0},
        '{'{REQ_LOG, 3'd3, 8'ha5, '{6'd42, 4'd9, 5'd20, 5'd17, 6'd45}}, 1'b0, '0},
        '{'{REQ_LOG, 3'd4, 8'd1, '{6'd1, 4'd1, 5'd1, 5'd1, 6'd1}}, 1'b0, '0},
        '{'{REQ_LOG, 3'd5, 8'd128, '{6'd62, 4'd14, 5'd30, 5'd30, 6'd62}}, 1'b0, '0},
        '{'{REQ_READ, 3'd6, 8'd1, '0}, 1'b1,
          '{1'b1, 8'd1, 12'd2005, 4'd12, 5'd1, 5'd23, 6'd59, 8'd1}},
        '{'{REQ_READ, 3'd5, 8'd1, '0}, 1'b0, '0},
        '{'{REQ_LOG, 3'd7, 8'd255, '{6'd63, 4'd15, 5'd31, 5'd31, 6'd63}}, 1'b1, '0},
        '{'{REQ_READ, 3'd0, 8'd1, '0}, 1'b1, '0},
        '{'{REQ_READ, 3'd2, 8'd1, '0}, 1'b0, '0}
    };

    localparam int FIXED_PHASES = 5;

    // Extremes of the capacity registers: 0 (taken as 1), 1 and 255.
    localparam t_capset PHASE_CAPS [FIXED_PHASES] = '{
        '{8'd1, 8'd2, 8'd3, 8'd4, 8'd7, 8'd255},
        '{8'd0, 8'd5, 8'd255, 8'd2, 8'd1, 8'd16},
        '{8'd3, 8'd1, 8'd6, 8'd255, 8'd0, 8'd2},
        '{8'd255, 8'd0, 8'd1, 8'd9, 8'd3, 8'd4},
        '{8'd200, 8'd200, 8'd100, 8'd100, 8'd50, 8'd50}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ekrl_in_if  in_bus ();
    ekrl_out_if out_bus ();

    multi_kind_event_ring_log dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state: capacities, per-kind pointers and the slot contents.
    logic [CAP_W-1:0] cap_setting  [NUM_CAP_REGS];
    logic [CNT_W-1:0] kind_count   [NUM_KINDS];
    logic [CNT_W-1:0] kind_newest  [NUM_KINDS];
    t_stamp           log_store    [NUM_KINDS][MAX_SLOTS];
    bit               slot_written [NUM_KINDS][MAX_SLOTS];

    t_result     awaited_results [$];
    t_result     awaited_head;
    int unsigned mismatch_count = 0;
    int unsigned stall_tick = 0;
    int unsigned stall_mode = 0;

    function automatic bit kind_ok(logic [KIND_W-1:0] kind);
        return kind != 0 && kind <= NUM_KINDS && kind <= NUM_CAP_REGS;
    endfunction

    function automatic int unsigned capacity_of(int unsigned k);
        return (cap_setting[k] == 0) ? 1 : cap_setting[k];
    endfunction

    function automatic int unsigned held_of(int unsigned k);
        int unsigned c;
        c = capacity_of(k);
        return (kind_count[k] > c) ? c : kind_count[k];
    endfunction

    // Slot that a read of entry n hits, or -1 when n is zero or too large.
    function automatic int read_slot(int unsigned k, int unsigned n);
        int unsigned c;
        int unsigned held;
        int unsigned back;
        c = capacity_of(k);
        held = held_of(k);
        if (n == 0 || n > held)
            return -1;
        back = (held - n) % c;
        return (kind_newest[k] % c + c - back) % c;
    endfunction

    function automatic t_result next_log_result(t_request r);
        t_result     res;
        t_stamp      st;
        int unsigned k;
        int unsigned c;
        int unsigned held;
        int unsigned slot;
        int          hit;
        res = '0;
        if (!kind_ok(r.kind))
            return res;
        k = r.kind - 1;
        c = capacity_of(k);
        held = held_of(k);
        if (r.op == REQ_LOG) begin
            if (held == 0)
                slot = 0;
            else
                slot = (kind_newest[k] + 1 >= c) ? 0 : kind_newest[k] + 1;
            held = (held < c) ? held + 1 : c;
            log_store[k][slot] = r.stamp;
            slot_written[k][slot] = 1'b1;
            kind_count[k] = CNT_W'(held);
            kind_newest[k] = CNT_W'(slot);
            st = r.stamp;
            res.found = 1'b1;
            res.order_number = 8'd1;
        end else begin
            hit = read_slot(k, r.entry_no);
            if (hit >= 0) begin
                st = log_store[k][hit];
                res.found = 1'b1;
                res.order_number = CNT_W'(held + 1 - r.entry_no);
            end
        end
        if (res.found) begin
            res.year_full = YEAR_BASE + YEAR_FULL_W'(st.year);
            res.month_out = st.month;
            res.day_out = st.day;
            res.hour_out = st.hour;
            res.minute_out = st.minute;
        end
        res.stored_count = CNT_W'(held);
        return res;
    endfunction

    task automatic issue_request(input t_request r, input logic typed, input t_result want);
        t_result res;
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.req_type <= r.op;
        in_bus.kind <= r.kind;
        in_bus.entry_number <= r.entry_no;
        in_bus.year_in <= r.stamp.year;
        in_bus.month_in <= r.stamp.month;
        in_bus.day_in <= r.stamp.day;
        in_bus.hour_in <= r.stamp.hour;
        in_bus.minute_in <= r.stamp.minute;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        res = next_log_result(r);
        awaited_results.push_back(typed ? want : res);
    endtask

    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        hold_off(1);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_caps(input t_capset v);
        for (int i = 0; i < NUM_CAP_REGS; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(i);
            i_cfg_data <= v[i];
            cap_setting[i] = v[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Receiver: the stall pattern is redrawn periodically among always
    // ready, random stalls, and a periodic ready.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall_tick++;
            if (stall_tick % 80 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_bus.ready <= 1'b1;
                1: out_bus.ready <= 1'($urandom_range(0, 1));
                default: out_bus.ready <= (stall_tick % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with no request outstanding");
                mismatch_count++;
            end else begin
                awaited_head = awaited_results.pop_front();
                check_field("found", awaited_head.found, out_bus.found);
                check_field("order_number", awaited_head.order_number,
                            out_bus.order_number);
                check_field("year_full", awaited_head.year_full, out_bus.year_full);
                check_field("month_out", awaited_head.month_out, out_bus.month_out);
                check_field("day_out", awaited_head.day_out, out_bus.day_out);
                check_field("hour_out", awaited_head.hour_out, out_bus.hour_out);
                check_field("minute_out", awaited_head.minute_out, out_bus.minute_out);
                check_field("stored_count", awaited_head.stored_count,
                            out_bus.stored_count);
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_request    r;
        t_capset     caps_next;
        logic [25:0] raw;
        int unsigned held;
        int unsigned pick;
        int unsigned burst_left;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.req_type = REQ_LOG;
        in_bus.kind = '0;
        in_bus.entry_number = '0;
        in_bus.year_in = '0;
        in_bus.month_in = '0;
        in_bus.day_in = '0;
        in_bus.hour_in = '0;
        in_bus.minute_in = '0;
        for (int k = 0; k < NUM_KINDS; k++) begin
            cap_setting[k] = CAP_RESET[k];
            kind_count[k] = '0;
            kind_newest[k] = '0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                log_store[k][s] = '0;
                slot_written[k][s] = 1'b0;
            end
        end
        burst_left = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS_N; i++)
            issue_request(DIR_ROWS[i].req, DIR_ROWS[i].typed, DIR_ROWS[i].want);

        for (int phase = 0; phase <= FIXED_PHASES; phase++) begin
            // Capacities change only once every result is back.
            wait_for_results();
            if (phase < FIXED_PHASES) begin
                caps_next = PHASE_CAPS[phase];
            end else begin
                for (int i = 0; i < NUM_CAP_REGS; i++)
                    caps_next[i] = ($urandom_range(0, 7) == 0) ? 8'd255
                                                              : 8'($urandom_range(0, 12));
            end
            write_caps(caps_next);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 40) == 0)
                        wait_for_results();
                    else if ($urandom_range(0, 2) != 0)
                        hold_off($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
                burst_left--;

                pick = $urandom_range(0, 19);
                if (pick == 0)
                    r.kind = 3'd0;
                else if (pick == 1)
                    r.kind = 3'd7;
                else
                    r.kind = KIND_W'($urandom_range(1, NUM_KINDS));
                r.op = ($urandom_range(0, 1) != 0) ? REQ_READ : REQ_LOG;
                raw = 26'($urandom);
                r.stamp = raw;
                r.entry_no = 8'($urandom);

                if (r.op == REQ_READ && kind_ok(r.kind)) begin
                    held = held_of(r.kind - 1);
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        r.entry_no = 8'd0;
                    else if (pick == 1 && held < 255)
                        r.entry_no = 8'($urandom_range(held + 1, 255));
                    else if (held > 0)
                        r.entry_no = 8'($urandom_range(1, held));
                    // A slot left unwritten after a capacity grew must not be read.
                    if (read_slot(r.kind - 1, r.entry_no) >= 0 &&
                        !slot_written[r.kind - 1][read_slot(r.kind - 1, r.entry_no)])
                        r.entry_no = 8'd0;
                end
                issue_request(r, 1'b0, '0);
            end
        end

        wait_for_results();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- multi_kind_event_ring_log.f -----
rtl/ekrl_pkg.sv
rtl/ekrl_stream_if.sv
rtl/ekrl_ptr_table.sv
rtl/ekrl_store.sv
rtl/ekrl_mod.sv
rtl/multi_kind_event_ring_log.sv
tb/multi_kind_event_ring_log_tb.sv
